/* design/jpeg_entropy_byte_unstuffer_macros.svh */
// ----------------------------------------------------------------------------
// jpeg_entropy_byte_unstuffer_macros.svh
// Assertion macros shared by the unstuffer checker.
// ----------------------------------------------------------------------------
`ifndef JPEG_ENTROPY_BYTE_UNSTUFFER_MACROS_SVH
`define JPEG_ENTROPY_BYTE_UNSTUFFER_MACROS_SVH

// same-cycle implication, disabled in reset
`define JEBU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jebu assertion failed");

// next-cycle implication, disabled in reset
`define JEBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jebu assertion failed");

`endif

/* design/jebu_pkg.sv */
// ----------------------------------------------------------------------------
// jebu_pkg
// Types and constants for the JPEG entropy-coded segment byte unstuffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jebu_pkg;

    localparam int COUNT_LIMIT_LOG2 = 28;
    localparam int CountW           = 29;

    localparam logic [CountW-1:0] COUNT_LIMIT = CountW'(1) << COUNT_LIMIT_LOG2;

    localparam logic [7:0] BYTE_FILL  = 8'hFF;
    localparam logic [7:0] BYTE_STUFF = 8'h00;
    localparam logic [7:0] RST_FIRST  = 8'hD0;
    localparam logic [7:0] RST_LAST   = 8'hD7;

    localparam logic [1:0] KIND_WORD     = 2'd0;
    localparam logic [1:0] KIND_BOUNDARY = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ORDER = 2'd1;
    localparam logic [1:0] STATUS_LONG  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } src_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [31:0] data_word;
        logic [30:0] bit_offset;
        logic [1:0]  end_status;
        logic        last_of_run;
    } rec_t;

endpackage

/* design/jpeg_entropy_byte_unstuffer.sv */
// ----------------------------------------------------------------------------
// jpeg_entropy_byte_unstuffer
// Removes byte stuffing and markers from a JPEG scan and packs kept bytes.
// ----------------------------------------------------------------------------
// Takes one scan byte per cycle while src_stall is low. Each accepted byte
// is decoded in a single pass against the scan state and leaves a small set
// of pending records (a packed word or restart boundary, then at scan end
// the padded partial word, two zero words and the end record). They leave
// one per cycle while rec_stall is low; a new byte is taken in the same
// cycle as the last pending record goes out. A byte that makes at most one
// record therefore need not stall the input; the byte that ends a scan
// holds it until all its records have passed the single record output port.
`timescale 1ns / 1ps

module jpeg_entropy_byte_unstuffer
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           src_valid,
    output logic           src_stall,
    input  jebu_pkg::src_t src_data,
    output logic           rec_valid,
    input  logic           rec_stall,
    output jebu_pkg::rec_t rec_data
);

    // scan state
    logic                        prefix_reg,  prefix_next;
    logic [jebu_pkg::CountW-1:0] count_reg,   count_next;
    logic [2:0]                  expect_reg,  expect_next;
    logic [23:0]                 pword_reg,   pword_next;
    logic [1:0]                  fill_reg,    fill_next;
    logic                        finished_reg, finished_next;

    // pending records: 0 first, 1 pad word, 2/3 zero words, 4 end record
    logic [4:0]  mask_reg,   mask_next;
    logic [1:0]  fkind_reg,  fkind_next;
    logic [31:0] fword_reg,  fword_next;
    logic [30:0] foff_reg,   foff_next;
    logic [31:0] pad_reg,    pad_next;
    logic [30:0] eoff_reg,   eoff_next;
    logic [1:0]  estat_reg,  estat_next;

    logic        src_accept;
    logic        rec_fire;
    logic        mask_last;
    logic [7:0]  b;
    logic        eoi;
    logic        keep;
    logic [7:0]  keep_val;
    logic        full_word;
    logic        boundary;
    logic        scan_end;
    logic [1:0]  status;
    logic [jebu_pkg::CountW-1:0] count_k;
    logic [23:0] pword_k;
    logic [1:0]  fill_k;
    logic [4:0]  new_mask;

    assign b   = src_data.data_byte;
    assign eoi = src_data.end_of_input;

    assign mask_last  = (mask_reg & (mask_reg - 5'd1)) == 5'd0;
    assign rec_valid  = mask_reg != 5'd0;
    assign rec_fire   = rec_valid && !rec_stall;
    assign src_stall  = !(mask_reg == 5'd0 || (mask_last && !rec_stall));
    assign src_accept = src_valid && !src_stall;

    always_comb
    begin
        prefix_next   = prefix_reg;
        count_next    = count_reg;
        expect_next   = expect_reg;
        pword_next    = pword_reg;
        fill_next     = fill_reg;
        finished_next = finished_reg;
        keep          = 1'b0;
        keep_val      = b;
        full_word     = 1'b0;
        boundary      = 1'b0;
        scan_end      = 1'b0;
        status        = jebu_pkg::STATUS_OK;
        count_k       = count_reg;
        pword_k       = pword_reg;
        fill_k        = fill_reg;
        new_mask      = 5'd0;
        fkind_next    = jebu_pkg::KIND_WORD;
        fword_next    = {pword_reg, b};
        foff_next     = 31'({count_reg, 3'b000});
        pad_next      = 32'd0;
        eoff_next     = 31'd0;
        estat_next    = jebu_pkg::STATUS_OK;

        if (finished_reg)
        begin
            if (eoi)
            begin
                prefix_next   = 1'b0;
                count_next    = '0;
                expect_next   = 3'd0;
                pword_next    = 24'd0;
                fill_next     = 2'd0;
                finished_next = 1'b0;
            end
        end
        else
        begin
            if (!prefix_reg)
            begin
                if (b == jebu_pkg::BYTE_FILL)
                    prefix_next = 1'b1;
                else
                    keep = 1'b1;
            end
            else if (b == jebu_pkg::BYTE_FILL)
            begin
                prefix_next = 1'b1;
            end
            else if (b == jebu_pkg::BYTE_STUFF)
            begin
                prefix_next = 1'b0;
                keep        = 1'b1;
                keep_val    = jebu_pkg::BYTE_FILL;
            end
            else if (b >= jebu_pkg::RST_FIRST && b <= jebu_pkg::RST_LAST)
            begin
                prefix_next = 1'b0;
                if (3'(b - jebu_pkg::RST_FIRST) == expect_reg)
                begin
                    boundary    = 1'b1;
                    fkind_next  = jebu_pkg::KIND_BOUNDARY;
                    fword_next  = 32'd0;
                    expect_next = expect_reg + 3'd1;
                end
                else
                begin
                    scan_end = 1'b1;
                    status   = jebu_pkg::STATUS_ORDER;
                end
            end
            else
            begin
                scan_end = 1'b1;
            end

            if (keep)
            begin
                fword_next = {pword_reg, keep_val};
                foff_next  = 31'd0;
                if (fill_reg == 2'd3)
                begin
                    full_word = 1'b1;
                    pword_k   = 24'd0;
                    fill_k    = 2'd0;
                end
                else
                begin
                    pword_k = {pword_reg[15:0], keep_val};
                    fill_k  = fill_reg + 2'd1;
                end
                count_k = count_reg + jebu_pkg::CountW'(1);
                if (count_k >= jebu_pkg::COUNT_LIMIT)
                begin
                    scan_end = 1'b1;
                    status   = jebu_pkg::STATUS_LONG;
                end
            end

            if (eoi)
                scan_end = 1'b1;

            pword_next = pword_k;
            fill_next  = fill_k;
            count_next = count_k;

            case (fill_k)
                2'd1:    pad_next = {pword_k[7:0], 24'd0};
                2'd2:    pad_next = {pword_k[15:0], 16'd0};
                2'd3:    pad_next = {pword_k, 8'd0};
                default: pad_next = 32'd0;
            endcase

            eoff_next  = (status == jebu_pkg::STATUS_LONG) ? 31'd0
                                                           : 31'({count_k, 3'b000});
            estat_next = status;

            new_mask[0] = full_word || boundary;
            if (scan_end)
            begin
                new_mask[1]   = fill_k != 2'd0;
                new_mask[2]   = 1'b1;
                new_mask[3]   = 1'b1;
                new_mask[4]   = 1'b1;
                prefix_next   = 1'b0;
                count_next    = '0;
                expect_next   = 3'd0;
                pword_next    = 24'd0;
                fill_next     = 2'd0;
                finished_next = !eoi;
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (src_accept)
            mask_next = new_mask;
        else if (rec_fire)
            mask_next = mask_reg & (mask_reg - 5'd1);
    end

    always_comb
    begin
        rec_data             = '0;
        rec_data.last_of_run = mask_last;
        if (mask_reg[0])
        begin
            rec_data.record_kind = fkind_reg;
            rec_data.data_word   = fword_reg;
            rec_data.bit_offset  = foff_reg;
        end
        else if (mask_reg[1])
        begin
            rec_data.record_kind = jebu_pkg::KIND_WORD;
            rec_data.data_word   = pad_reg;
        end
        else if (mask_reg[2] || mask_reg[3])
        begin
            rec_data.record_kind = jebu_pkg::KIND_WORD;
        end
        else
        begin
            rec_data.record_kind = jebu_pkg::KIND_END;
            rec_data.bit_offset  = eoff_reg;
            rec_data.end_status  = estat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg   <= 1'b0;
            count_reg    <= '0;
            expect_reg   <= 3'd0;
            pword_reg    <= 24'd0;
            fill_reg     <= 2'd0;
            finished_reg <= 1'b0;
            mask_reg     <= 5'd0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (src_accept)
            begin
                prefix_reg   <= prefix_next;
                count_reg    <= count_next;
                expect_reg   <= expect_next;
                pword_reg    <= pword_next;
                fill_reg     <= fill_next;
                finished_reg <= finished_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_accept)
        begin
            fkind_reg <= fkind_next;
            fword_reg <= fword_next;
            foff_reg  <= foff_next;
            pad_reg   <= pad_next;
            eoff_reg  <= eoff_next;
            estat_reg <= estat_next;
        end
    end

endmodule

/* design/jebu_checker.sv */
// ----------------------------------------------------------------------------
// jebu_checker
// Port-level checks on the unstuffer handshakes and records, bound to the top
// level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jpeg_entropy_byte_unstuffer_macros.svh"

module jebu_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           src_valid,
    input logic           src_stall,
    input jebu_pkg::src_t src_data,
    input logic           rec_valid,
    input logic           rec_stall,
    input jebu_pkg::rec_t rec_data
);

    logic is_end;
    logic is_word;
    logic src_wait;
    logic side_clear;

    assign is_end     = rec_data.record_kind == jebu_pkg::KIND_END;
    assign is_word    = rec_data.record_kind == jebu_pkg::KIND_WORD;
    assign src_wait   = src_valid && src_stall;
    assign side_clear = rec_data.bit_offset == 31'd0
                        && rec_data.end_status == jebu_pkg::STATUS_OK;

    // a stalled input byte stays offered and unchanged
    `JEBU_ASSERT_NEXT(a_src_hold, clk, rst_n, src_wait, src_valid && $stable(src_data))
    // a stalled record stays offered
    `JEBU_ASSERT_NEXT(a_rec_hold, clk, rst_n, rec_valid && rec_stall, rec_valid)
    // the end record always closes the run of its input byte
    `JEBU_ASSERT_NOW(a_end_last, clk, rst_n, rec_valid && is_end, rec_data.last_of_run)
    // only data words carry data
    `JEBU_ASSERT_NOW(a_word_only, clk, rst_n, rec_valid && !is_word, rec_data.data_word == 32'd0)
    // data words carry no offset or status
    `JEBU_ASSERT_NOW(a_word_clean, clk, rst_n, rec_valid && is_word, side_clear)

endmodule

bind jpeg_entropy_byte_unstuffer jebu_checker u_jebu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_data  (rec_data)
);
